// ===== sv/sdrq_pkg.sv =====
// Shared constants for the sorted delay ready queue.
package sdrq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int KEY_WIDTH_DEF   = 32;

    localparam int TASK_ID_W = 8;
    localparam int DELAY_W   = 32;

    // Request codes carried in req_type
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

endpackage

// ===== sv/sdrq_in_if.sv =====
// Request channel: valid/ready handshake with the insert/drain payload.
interface sdrq_in_if;
    import sdrq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [TASK_ID_W-1:0] task_id;
    logic [DELAY_W-1:0]   delay_time;

    modport source (output valid, req_type, task_id, delay_time, input ready);
    modport sink   (input valid, req_type, task_id, delay_time, output ready);
endinterface

// ===== sv/sdrq_out_if.sv =====
// Result channel: valid/ready handshake with the ready-task payload.
interface sdrq_out_if;
    import sdrq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TASK_ID_W-1:0] ready_task_id;
    logic                 last_of_run;
    logic                 overflow;

    modport source (output valid, ready_task_id, last_of_run, overflow, input ready);
    modport sink   (input valid, ready_task_id, last_of_run, overflow, output ready);
endinterface

// ===== sv/sdrq_store.sv =====
// Slot memory: one write port, one read port with registered read data.
module sdrq_store #(
    parameter int DEPTH = sdrq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_W = sdrq_pkg::KEY_WIDTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [IDX_W-1:0]               wr_addr,
    input  logic [KEY_W-1:0]               wr_key,
    input  logic [sdrq_pkg::TASK_ID_W-1:0] wr_id,
    input  logic [IDX_W-1:0]               rd_addr,
    output logic [KEY_W-1:0]               rd_key,
    output logic [sdrq_pkg::TASK_ID_W-1:0] rd_id
);
    import sdrq_pkg::*;

    logic [KEY_W-1:0]     key_mem [DEPTH];
    logic [TASK_ID_W-1:0] id_mem  [DEPTH];

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            id_mem[wr_addr]  <= wr_id;
        end
        rd_key <= key_mem[rd_addr];
        rd_id  <= id_mem[rd_addr];
    end

endmodule

// ===== sv/sorted_delay_ready_queue_top.sv =====
// Sorted delay ready queue: top level with sequencer, compare unit and output register.
// Insert: into an empty queue the entry is written straight to slot 0 on accept; else the walk reads
//   and compares slots from the tail, shifting each larger key up, until the entry is placed or becomes the new head.
// Drain: each entry is read from slot memory, then loaded into the output register once it is free.
// Overflow: ST_OVF loads the rejected task into the output register once it is free. Words are taken only in idle.
// Reset (rst_n low, async) empties the queue; slot memory is not cleared, no sweep.
module sorted_delay_ready_queue_top #(
    parameter int QUEUE_DEPTH = sdrq_pkg::QUEUE_DEPTH_DEF,
    parameter int KEY_WIDTH   = sdrq_pkg::KEY_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    sdrq_in_if.sink    req,
    sdrq_out_if.source rsp
);
    import sdrq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,    // read slot idx
        ST_INS_CMP,   // compare against slot idx, shift it up or place new entry
        ST_INS_HEAD,  // new entry goes to slot 0
        ST_DRN_RD,    // read slot idx
        ST_DRN_LD,    // load slot idx into the output register
        ST_OVF        // report the rejected task
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [KEY_WIDTH-1:0] new_key_reg;
    logic [TASK_ID_W-1:0] new_id_reg;

    logic                 out_valid_reg;
    logic [TASK_ID_W-1:0] out_id_reg;
    logic                 out_last_reg;
    logic                 out_ovf_reg;

    // Slot memory ports
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_key;
    logic [TASK_ID_W-1:0] wr_id;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [TASK_ID_W-1:0] rd_id;

    logic                 req_acc;
    logic                 out_free;
    logic                 out_load;
    logic                 full;
    logic                 last_idx;
    logic                 key_before;
    logic [KEY_WIDTH-1:0] req_key;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_acc   = req.valid && req.ready;

    // Output register frees up when empty or when its word is taken this cycle
    assign out_free = !out_valid_reg || rsp.ready;
    // A new word goes into the output register this cycle
    assign out_load = out_free && ((state_reg == ST_DRN_LD) || (state_reg == ST_OVF));
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign last_idx = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Key is kept at KEY_WIDTH bits: truncated or zero-extended
    assign req_key = KEY_WIDTH'(req.delay_time);

    // The one comparator: strict less-than keeps equal keys in arrival order
    assign key_before = (new_key_reg < rd_key);

    assign rsp.valid         = out_valid_reg;
    assign rsp.ready_task_id = out_id_reg;
    assign rsp.last_of_run   = out_last_reg;
    assign rsp.overflow      = out_ovf_reg;

    // Write port: tail-first shift, one entry per compare
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg + IDX_W'(1);
        wr_key  = rd_key;
        wr_id   = rd_id;
        case (state_reg)
            ST_IDLE:
            begin
                // Insert into an empty queue lands straight in slot 0
                if (req_acc && req.req_type == REQ_INSERT && count_reg == '0)
                begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_key  = req_key;
                    wr_id   = req.task_id;
                end
            end
            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (!key_before)
                begin
                    wr_key = new_key_reg;
                    wr_id  = new_id_reg;
                end
            end
            ST_INS_HEAD:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_key  = new_key_reg;
                wr_id   = new_id_reg;
            end
            default:
            begin
            end
        endcase
    end

    sdrq_store #(
        .DEPTH (QUEUE_DEPTH),
        .KEY_W (KEY_WIDTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_id   (wr_id),
        .rd_addr (idx_reg),
        .rd_key  (rd_key),
        .rd_id   (rd_id)
    );

    // Sequencer, entry count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            new_key_reg   <= '0;
            new_id_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_acc)
                    begin
                        new_key_reg <= req_key;
                        new_id_reg  <= req.task_id;
                        if (req.req_type == REQ_INSERT)
                        begin
                            if (full)
                            begin
                                state_reg <= ST_OVF;
                            end
                            else if (count_reg == '0)
                            begin
                                count_reg <= CNT_W'(1);
                            end
                            else
                            begin
                                // Walk from the tail toward the head
                                idx_reg   <= IDX_W'(count_reg - CNT_W'(1));
                                state_reg <= ST_INS_RD;
                            end
                        end
                        else if (count_reg != '0)
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_DRN_RD;
                        end
                    end
                end
                ST_INS_RD:
                begin
                    state_reg <= ST_INS_CMP;
                end
                ST_INS_CMP:
                begin
                    if (key_before)
                    begin
                        // Slot idx moved up; keep walking or place at the head
                        if (idx_reg == '0)
                        begin
                            state_reg <= ST_INS_HEAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - IDX_W'(1);
                            state_reg <= ST_INS_RD;
                        end
                    end
                    else
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_INS_HEAD:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= ST_IDLE;
                end
                ST_DRN_RD:
                begin
                    state_reg <= ST_DRN_LD;
                end
                ST_DRN_LD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= rd_id;
                        out_last_reg  <= last_idx;
                        out_ovf_reg   <= 1'b0;
                        if (last_idx)
                        begin
                            count_reg <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + IDX_W'(1);
                            state_reg <= ST_DRN_RD;
                        end
                    end
                end
                ST_OVF:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= new_id_reg;
                        out_last_reg  <= 1'b1;
                        out_ovf_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/sdrq_checker.sv =====
// Port-level checks for the sorted delay ready queue, bound to the top level.
module sdrq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           req_type,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [sdrq_pkg::TASK_ID_W-1:0] rsp_id,
    input logic                           rsp_last,
    input logic                           rsp_ovf
);
    import sdrq_pkg::*;

    // A stalled word stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    // A stalled word keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_id) && $stable(rsp_last) && $stable(rsp_ovf))
        else $error("result payload changed while stalled");

    // An overflow report is always the only word of its run
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ovf |-> rsp_last)
        else $error("overflow word without last mark");

    // No result word can start in the cycle right after an insert is taken
    a_ins_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req_type == REQ_INSERT |=> !$rose(rsp_valid))
        else $error("result word appeared right after an insert");

endmodule

bind sorted_delay_ready_queue_top sdrq_checker u_sdrq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_id    (rsp.ready_task_id),
    .rsp_last  (rsp.last_of_run),
    .rsp_ovf   (rsp.overflow)
);
